// File: sv/iptp_pkg.sv
package iptp_pkg;

    // address geometry
    localparam int ADDR_BYTES  = 16;
    localparam int V4_BYTES    = 4;
    localparam int GROUP_BYTES = 2;
    localparam int OCTET_MAX   = 255;
    localparam int GROUP_MAX_PRE_SHIFT = 16'h0fff;

    // characters of interest
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    // family selector
    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    // result status
    localparam logic [1:0] ST_REJECT      = 2'd0;
    localparam logic [1:0] ST_ACCEPT      = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    typedef enum logic [1:0] {
        PH_START,
        PH_LEAD_COLON,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] family;
    } t_char_req;

    typedef struct packed {
        logic [1:0]   status;
        logic [127:0] addr;
    } t_result;

endpackage

// File: sv/iptp_core.sv
module iptp_core
    import iptp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_char_req i_req,
    output t_result   o_res
);

    // bytes placed before the gap, byte 0 in the top bits
    logic [0:15][7:0] r_head, n_head;
    // bytes after the gap (and IPv4 octets), shifted in from the bottom
    logic [127:0]     r_tail, n_tail;
    logic [4:0]       r_bc, n_bc;
    logic [4:0]       r_gp, n_gp;
    logic             r_gap, n_gap;
    logic [15:0]      r_gv, n_gv;
    logic             r_ghd, n_ghd;
    logic [7:0]       r_td, n_td;
    logic             r_tdok, n_tdok;
    logic [2:0]       r_oc, n_oc;
    logic             r_ohd, n_ohd;
    logic             r_dotted, n_dotted;
    logic             r_failed, n_failed;
    t_phase           r_phase, n_phase;
    logic             r_tsc, n_tsc;
    logic [1:0]       r_fam, n_fam;

    logic [1:0]  fam;
    logic [7:0]  ch;
    logic        is_digit;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [11:0] acc_n;
    logic        route_tail;
    logic        put_grp;
    logic        put_new;
    logic        put_upd;
    logic [7:0]  put_val;
    logic [3:0]  put_idx;

    // finish path
    logic [0:15][7:0] f_head;
    logic [127:0]     f_tail;
    logic [4:0]       f_bc;
    logic             f_ok;

    assign ch  = i_req.ch;
    assign fam = (r_phase == PH_START) ? i_req.family : r_fam;

    always_comb begin
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_hex   = is_digit || ((ch >= CH_LC_A) && (ch <= CH_LC_F))
                   || ((ch >= CH_UC_A) && (ch <= CH_UC_F));
        hex_val  = is_digit ? ch[3:0] : 4'(ch[3:0] + 4'd9);
        // td * 10 + digit
        acc_n    = {1'b0, r_td, 3'b000} + {3'b000, r_td, 1'b0} + {8'h00, hex_val};
    end

    assign route_tail = (fam == FAM_IPV4) || r_gap;

    // next state
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_bc     = r_bc;
        n_gp     = r_gp;
        n_gap    = r_gap;
        n_gv     = r_gv;
        n_ghd    = r_ghd;
        n_td     = r_td;
        n_tdok   = r_tdok;
        n_oc     = r_oc;
        n_ohd    = r_ohd;
        n_dotted = r_dotted;
        n_failed = r_failed;
        n_phase  = r_phase;
        n_tsc    = r_tsc;
        n_fam    = r_fam;
        put_grp  = 1'b0;
        put_new  = 1'b0;
        put_upd  = 1'b0;
        put_val  = r_td;
        put_idx  = '0;

        if (i_step) begin
            n_fam = fam;
            if (ch == CH_END) begin
                n_head   = '0;
                n_tail   = '0;
                n_bc     = '0;
                n_gp     = '0;
                n_gap    = 1'b0;
                n_gv     = '0;
                n_ghd    = 1'b0;
                n_td     = '0;
                n_tdok   = 1'b1;
                n_oc     = '0;
                n_ohd    = 1'b0;
                n_dotted = 1'b0;
                n_failed = 1'b0;
                n_phase  = PH_START;
                n_tsc    = 1'b0;
                n_fam    = FAM_IPV4;
            end else if (fam[1] || r_failed) begin
                n_phase = PH_BODY;
            end else if ((fam == FAM_IPV4) || r_dotted) begin
                // dotted decimal octets
                n_phase = PH_BODY;
                if (is_digit) begin
                    if (r_ohd && (r_td == 8'd0)) begin
                        n_failed = 1'b1;
                    end else if (acc_n > 12'(OCTET_MAX)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_td    = acc_n[7:0];
                        put_val = acc_n[7:0];
                        if (!r_ohd) begin
                            if (r_oc >= 3'(V4_BYTES)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_oc    = 3'(r_oc + 3'd1);
                                n_ohd   = 1'b1;
                                put_new = 1'b1;
                            end
                        end else begin
                            put_upd = 1'b1;
                        end
                    end
                end else if (ch == CH_DOT) begin
                    if (!r_ohd || (r_oc == 3'(V4_BYTES))) begin
                        n_failed = 1'b1;
                    end else begin
                        n_ohd = 1'b0;
                        n_td  = '0;
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end else if ((r_phase == PH_START) && (ch == CH_COLON)) begin
                n_phase = PH_LEAD_COLON;
            end else if ((r_phase == PH_LEAD_COLON) && (ch != CH_COLON)) begin
                n_failed = 1'b1;
                n_phase  = PH_BODY;
            end else begin
                n_phase = PH_BODY;
                if (is_hex) begin
                    if (r_gv > 16'(GROUP_MAX_PRE_SHIFT)) begin
                        n_failed = 1'b1;
                    end else begin
                        // decimal view of the same token, for a dotted tail
                        if (r_tdok) begin
                            if (!is_digit || (r_ghd && (r_td == 8'd0))) begin
                                n_tdok = 1'b0;
                            end else if (acc_n > 12'(OCTET_MAX)) begin
                                n_tdok = 1'b0;
                            end else begin
                                n_td = acc_n[7:0];
                            end
                        end
                        n_gv  = {r_gv[11:0], hex_val};
                        n_ghd = 1'b1;
                        n_tsc = 1'b0;
                    end
                end else if (ch == CH_COLON) begin
                    n_td   = '0;
                    n_tdok = 1'b1;
                    if (!r_ghd) begin
                        if (r_gap) begin
                            n_failed = 1'b1;
                        end else begin
                            n_gap = 1'b1;
                            n_gp  = r_bc;
                            n_tsc = 1'b0;
                        end
                    end else if (r_bc > 5'(ADDR_BYTES - GROUP_BYTES)) begin
                        n_failed = 1'b1;
                    end else begin
                        put_grp = 1'b1;
                        n_bc    = 5'(r_bc + 5'(GROUP_BYTES));
                        n_gv    = '0;
                        n_ghd   = 1'b0;
                        n_tsc   = 1'b1;
                    end
                end else if ((ch == CH_DOT) && (r_bc <= 5'(ADDR_BYTES - V4_BYTES))
                             && r_ghd && r_tdok) begin
                    // first octet of an embedded IPv4 part
                    put_new  = 1'b1;
                    put_val  = r_td;
                    n_td     = '0;
                    n_oc     = 3'd1;
                    n_ohd    = 1'b0;
                    n_dotted = 1'b1;
                    n_gv     = '0;
                    n_ghd    = 1'b0;
                    n_tsc    = 1'b0;
                end else begin
                    n_failed = 1'b1;
                end
            end

            // byte placement
            put_idx = 4'(r_bc[3:0] + {1'b0, n_oc} - 4'd1);
            if (put_grp) begin
                if (route_tail) begin
                    n_tail = {r_tail[111:0], r_gv};
                end else begin
                    n_head[r_bc[3:0]]          = r_gv[15:8];
                    n_head[4'(r_bc[3:0] + 4'd1)] = r_gv[7:0];
                end
            end
            if (put_new || put_upd) begin
                if (route_tail) begin
                    if (put_new) begin
                        n_tail = {r_tail[119:0], put_val};
                    end else begin
                        n_tail[7:0] = put_val;
                    end
                end else begin
                    n_head[put_idx] = put_val;
                end
            end
        end
    end

    // result for a terminator
    always_comb begin
        f_head = r_head;
        f_tail = r_tail;
        f_bc   = r_bc;
        f_ok   = 1'b1;
        o_res  = '{status: ST_REJECT, addr: '0};

        if (r_phase == PH_LEAD_COLON) begin
            f_ok = 1'b0;
        end
        if (r_dotted) begin
            if (r_oc != 3'(V4_BYTES)) begin
                f_ok = 1'b0;
            end
            f_bc = 5'(r_bc + 5'(V4_BYTES));
        end else if (r_ghd) begin
            if (r_bc > 5'(ADDR_BYTES - GROUP_BYTES)) begin
                f_ok = 1'b0;
            end
            f_bc = 5'(r_bc + 5'(GROUP_BYTES));
            if (r_gap) begin
                f_tail = {r_tail[111:0], r_gv};
            end else begin
                f_head[r_bc[3:0]]            = r_gv[15:8];
                f_head[4'(r_bc[3:0] + 4'd1)] = r_gv[7:0];
            end
        end
        if (r_tsc) begin
            f_ok = 1'b0;
        end
        if (r_gap) begin
            if ((f_bc >= 5'(ADDR_BYTES)) || (r_gp > f_bc)) begin
                f_ok = 1'b0;
            end
        end else if (f_bc != 5'(ADDR_BYTES)) begin
            f_ok = 1'b0;
        end

        if (fam[1]) begin
            o_res.status = ST_UNSUPPORTED;
        end else if (r_failed) begin
            o_res.status = ST_REJECT;
        end else if (fam == FAM_IPV4) begin
            if (r_oc == 3'(V4_BYTES)) begin
                o_res.status = ST_ACCEPT;
                o_res.addr   = {96'h0, r_tail[31:0]};
            end
        end else if (f_ok) begin
            // head holds the front, tail is right-aligned: the gap is the zeros between
            o_res.status = ST_ACCEPT;
            o_res.addr   = f_head | f_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_bc     <= '0;
            r_gp     <= '0;
            r_gap    <= 1'b0;
            r_gv     <= '0;
            r_ghd    <= 1'b0;
            r_td     <= '0;
            r_tdok   <= 1'b1;
            r_oc     <= '0;
            r_ohd    <= 1'b0;
            r_dotted <= 1'b0;
            r_failed <= 1'b0;
            r_phase  <= PH_START;
            r_tsc    <= 1'b0;
            r_fam    <= FAM_IPV4;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_bc     <= n_bc;
            r_gp     <= n_gp;
            r_gap    <= n_gap;
            r_gv     <= n_gv;
            r_ghd    <= n_ghd;
            r_td     <= n_td;
            r_tdok   <= n_tdok;
            r_oc     <= n_oc;
            r_ohd    <= n_ohd;
            r_dotted <= n_dotted;
            r_failed <= n_failed;
            r_phase  <= n_phase;
            r_tsc    <= n_tsc;
            r_fam    <= n_fam;
        end
    end

endmodule

// File: sv/ip_address_text_parser_unit.sv
// A terminator is held in the input register; its result is registered in the result register.
// Throughput: one character per cycle; the only stall is a terminator meeting a full result
//   register that the master side has not yet taken.
// Reset: synchronous, active low; clears the input and result valid flags and all parse state,
//   which also returns to its reset value after every terminator.
module ip_address_text_parser_unit
    import iptp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] ch
    input  logic [1:0]   i_s_tuser,   // [1:0] family
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic [1:0]   o_m_tuser    // [1:0] status
);

    // input register
    logic      r_in_valid, n_in_valid;
    t_char_req r_in, n_in;

    // result register
    logic      r_out_valid, n_out_valid;
    t_result   r_out, n_out;

    logic      w_is_end;
    logic      w_advance;
    t_result   w_res;

    assign w_is_end = (r_in.ch == CH_END);
    // plain characters always move on; a terminator needs room in the result register
    assign w_advance = r_in_valid && (!w_is_end || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    iptp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_req   (r_in),
        .o_res   (w_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (o_s_tready) begin
            n_in_valid = i_s_tvalid;
            n_in       = '{ch: i_s_tdata, family: i_s_tuser};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_advance && w_is_end) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {r_out.addr[63:0], r_out.addr[127:64]};

`ifndef SYNTHESIS
    // a processed terminator always lands in the result register
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_end) |=> o_m_tvalid)
        else $error("terminator processed without a result");

    // only an accepted text carries an address
    a_reject_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_ACCEPT)) |-> (o_m_tdata == '0))
        else $error("non-accepted result with non-zero address");

    // ordinary characters never hold up the slave side
    a_char_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_is_end) |-> o_s_tready)
        else $error("stall on an ordinary character");
`endif

endmodule
